>>> rtl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg - shared types and constants of the JSON string unescape unit
// Result status codes, input operation codes, character codes and the
// hex digit decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

	typedef enum logic [1:0] {
		STATUS_BYTE = 2'd0,
		STATUS_DONE = 2'd1,
		STATUS_ERR  = 2'd2
	} status_t;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_END  = 1'b1
	} op_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;

	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_TAB = 8'h09;

	// lowest byte allowed raw inside a string
	localparam logic [7:0] MIN_RAW = 8'h20;

	localparam logic [2:0] HEX_DIGITS = 3'd4;

	// UTF-8 lead and continuation marks
	localparam logic [2:0] LEAD2 = 3'b110;
	localparam logic [3:0] LEAD3 = 4'b1110;
	localparam logic [1:0] CONT = 2'b10;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.val = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/json_string_unescape_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_unit - JSON string literal decoder with UTF-8 output
// Takes a quoted JSON string one byte per transfer and returns the decoded
// bytes, a completion mark at the closing quote, or a parse error.
// ----------------------------------------------------------------------------
// The unit accepts one input transfer and returns one result transfer per
// cycle when not stalled. An input is held in an input register, decoded
// combinationally against the parser state and written as a bundle of up
// to three results to the result register, which then presents them one
// per cycle while out_stall is low. An input that yields n results thus
// occupies the output for n transfers; a backslash-u escape takes six
// inputs for at most three results, so a steady byte stream moves at one
// byte per cycle without stalls. While the result register drains, one
// further input waits in the input register.

module json_string_unescape_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       op,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic [1:0]      status,
	output logic            last
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_STR  = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// parser state
	phase_t      phase_q;
	logic [2:0]  digits_q;
	logic [15:0] cp_q;

	// result bundle
	logic                  bund_valid_s2;
	logic [1:0]            cnt_s2;
	logic [1:0]            idx_s2;
	jsu_pkg::status_t      st_s2;
	logic [2:0][7:0]       bytes_s2;

	// decode of the held input
	phase_t           phase_d;
	logic [2:0]       digits_d;
	logic [15:0]      cp_d;
	logic [1:0]       res_cnt;
	logic [2:0][7:0]  res_bytes;
	jsu_pkg::status_t res_st;
	jsu_pkg::hex_t    hex;
	logic [15:0]      cp_new;

	logic out_xfer;
	logic bund_drain;
	logic adv;

	assign out_xfer = bund_valid_s2 && !out_stall;
	assign bund_drain = out_xfer && (idx_s2 == cnt_s2 - 2'd1);
	// advance when the bundle is free or drains now, or the item yields nothing
	assign adv = valid_s1 && (!bund_valid_s2 || bund_drain || res_cnt == 2'd0);
	assign in_stall = valid_s1 && !adv;

	assign hex = jsu_pkg::hex_decode(byte_s1);
	assign cp_new = {cp_q[11:0], hex.val};

	always_comb begin
		phase_d = phase_q;
		digits_d = digits_q;
		cp_d = cp_q;
		res_cnt = 2'd0;
		res_bytes = '0;
		res_st = jsu_pkg::STATUS_BYTE;
		if (op_s1 == jsu_pkg::OP_END) begin
			phase_d = PH_IDLE;
			digits_d = 3'd0;
			cp_d = 16'd0;
			res_cnt = 2'd1;
			res_st = jsu_pkg::STATUS_ERR;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (byte_s1 == jsu_pkg::CH_QUOTE) begin
						phase_d = PH_STR;
					end else begin
						res_cnt = 2'd1;
						res_st = jsu_pkg::STATUS_ERR;
						digits_d = 3'd0;
						cp_d = 16'd0;
					end
				end
				PH_STR: begin
					if (byte_s1 == jsu_pkg::CH_QUOTE) begin
						phase_d = PH_IDLE;
						res_cnt = 2'd1;
						res_st = jsu_pkg::STATUS_DONE;
					end else if (byte_s1 == jsu_pkg::CH_BSLASH) begin
						phase_d = PH_ESC;
					end else if (byte_s1 < jsu_pkg::MIN_RAW) begin
						phase_d = PH_IDLE;
						digits_d = 3'd0;
						cp_d = 16'd0;
						res_cnt = 2'd1;
						res_st = jsu_pkg::STATUS_ERR;
					end else begin
						res_cnt = 2'd1;
						res_bytes[0] = byte_s1;
					end
				end
				PH_ESC: begin
					phase_d = PH_STR;
					res_cnt = 2'd1;
					case (byte_s1)
						jsu_pkg::CH_QUOTE:  res_bytes[0] = jsu_pkg::CH_QUOTE;
						jsu_pkg::CH_BSLASH: res_bytes[0] = jsu_pkg::CH_BSLASH;
						jsu_pkg::CH_SLASH:  res_bytes[0] = jsu_pkg::CH_SLASH;
						jsu_pkg::CH_B:      res_bytes[0] = jsu_pkg::CTL_BS;
						jsu_pkg::CH_F:      res_bytes[0] = jsu_pkg::CTL_FF;
						jsu_pkg::CH_N:      res_bytes[0] = jsu_pkg::CTL_LF;
						jsu_pkg::CH_R:      res_bytes[0] = jsu_pkg::CTL_CR;
						jsu_pkg::CH_T:      res_bytes[0] = jsu_pkg::CTL_TAB;
						jsu_pkg::CH_U: begin
							phase_d = PH_HEX;
							digits_d = 3'd0;
							cp_d = 16'd0;
							res_cnt = 2'd0;
						end
						default: begin
							phase_d = PH_IDLE;
							digits_d = 3'd0;
							cp_d = 16'd0;
							res_st = jsu_pkg::STATUS_ERR;
						end
					endcase
				end
				default: begin
					if (!hex.ok) begin
						phase_d = PH_IDLE;
						digits_d = 3'd0;
						cp_d = 16'd0;
						res_cnt = 2'd1;
						res_st = jsu_pkg::STATUS_ERR;
					end else if (digits_q + 3'd1 != jsu_pkg::HEX_DIGITS) begin
						digits_d = digits_q + 3'd1;
						cp_d = cp_new;
					end else begin
						// fourth digit: emit the code point as UTF-8
						phase_d = PH_STR;
						digits_d = 3'd0;
						cp_d = 16'd0;
						if (cp_new[15:7] == 9'd0) begin
							res_cnt = 2'd1;
							res_bytes[0] = cp_new[7:0];
						end else if (cp_new[15:11] == 5'd0) begin
							res_cnt = 2'd2;
							res_bytes[0] = {jsu_pkg::LEAD2, cp_new[10:6]};
							res_bytes[1] = {jsu_pkg::CONT, cp_new[5:0]};
						end else begin
							res_cnt = 2'd3;
							res_bytes[0] = {jsu_pkg::LEAD3, cp_new[15:12]};
							res_bytes[1] = {jsu_pkg::CONT, cp_new[11:6]};
							res_bytes[2] = {jsu_pkg::CONT, cp_new[5:0]};
						end
					end
				end
			endcase
		end
	end

	// control: input valid, parser state, bundle occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q <= PH_IDLE;
			digits_q <= 3'd0;
			cp_q <= 16'd0;
			bund_valid_s2 <= 1'b0;
			cnt_s2 <= 2'd0;
			idx_s2 <= 2'd0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				phase_q <= phase_d;
				digits_q <= digits_d;
				cp_q <= cp_d;
			end
			if (adv && res_cnt != 2'd0) begin
				// load a new bundle
				bund_valid_s2 <= 1'b1;
				cnt_s2 <= res_cnt;
				idx_s2 <= 2'd0;
			end else if (bund_drain) begin
				bund_valid_s2 <= 1'b0;
			end else if (out_xfer) begin
				idx_s2 <= idx_s2 + 2'd1;
			end
		end
	end

	// payload: hold the input item and the result bytes
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= op;
			byte_s1 <= in_byte;
		end
		if (adv && res_cnt != 2'd0) begin
			bytes_s2 <= res_bytes;
			st_s2 <= res_st;
		end
	end

	assign out_valid = bund_valid_s2;
	assign out_byte = bytes_s2[idx_s2];
	assign status = st_s2;
	assign last = (idx_s2 == cnt_s2 - 2'd1);

endmodule
`default_nettype wire
